// File: rtl/core/ecbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbb_pkg
// Shared types and constants of the edge content bounding box core.
// ----------------------------------------------------------------------------
package ecbb_pkg;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;
  localparam logic [1:0] REG_MODE      = 2'd3;

  localparam logic [1:0] MODE_GRAY  = 2'd0;
  localparam logic [1:0] MODE_BGR   = 2'd1;
  localparam logic [1:0] MODE_BGRX  = 2'd2;
  localparam logic [1:0] MODE_BGRA  = 2'd3;

  localparam logic [10:0] COEF_B = 11'd233;
  localparam logic [10:0] COEF_G = 11'd1197;
  localparam logic [10:0] COEF_R = 11'd610;
  localparam int          MIX_SHIFT   = 11;
  localparam int          ALPHA_SHIFT = 19;

  typedef struct packed {
    logic accept;
    logic mix;
    logic prod;
    logic shade;
    logic grad;
    logic merge;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_pix;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] absdiff8(input logic [7:0] x, input logic [7:0] y);
    absdiff8 = (x > y) ? (x - y) : (y - x);
  endfunction

endpackage

// File: rtl/core/ecbb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbb_ctrl
// Sequencer: steps each item through mix, product, shade, gradient, merge.
// ----------------------------------------------------------------------------
module ecbb_ctrl import ecbb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MIX   = 3'd1;
  localparam logic [2:0] S_PROD  = 3'd2;
  localparam logic [2:0] S_SHADE = 3'd3;
  localparam logic [2:0] S_GRAD  = 3'd4;
  localparam logic [2:0] S_MERGE = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_SHADE;
      end
      S_SHADE: begin
        cmd.shade = 1'b1;
        state_nxt = S_GRAD;
      end
      S_GRAD: begin
        cmd.grad  = 1'b1;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = sts.last_pix ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.mix, cmd.prod, cmd.shade, cmd.grad, cmd.merge, cmd.emit}))
    else $error("more than one step command");
  a_accept_mix: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.mix)
    else $error("accepted item not mixed");
  a_merge_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge |=> (state_r == S_IDLE || state_r == S_EMIT))
    else $error("bad state after merge");
`endif

endmodule

// File: rtl/core/ecbb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbb_datapath
// Gray conversion, line store, 3x3 window, Scharr test and box tracking.
// ----------------------------------------------------------------------------
module ecbb_datapath import ecbb_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [31:0] in_tdata,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic        out_tuser
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  function automatic logic [WW-1:0] clamp_w(input logic [11:0] v);
    if (v == 12'd0) clamp_w = WW'(1);
    else if (18'(v) > 18'(MAX_WIDTH)) clamp_w = WW'(MAX_WIDTH);
    else clamp_w = WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [12:0] v);
    if (v == 13'd0) clamp_h = HW'(1);
    else if (18'(v) > 18'(MAX_HEIGHT)) clamp_h = HW'(MAX_HEIGHT);
    else clamp_h = HW'(v);
  endfunction

  // configuration
  logic [7:0]  thr_r;
  logic [11:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  mode_r;
  logic [WW-1:0] w_eff, w_start;
  logic [HW-1:0] h_eff, h_start;
  logic geo_wr;

  assign w_eff  = clamp_w(width_r);
  assign h_eff  = clamp_h(height_r);
  assign geo_wr = cfg_wr_en && (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT);
  assign w_start = (cfg_wr_en && cfg_addr == REG_WIDTH) ? clamp_w(cfg_wdata[11:0]) : w_eff;
  assign h_start = (cfg_wr_en && cfg_addr == REG_HEIGHT) ? clamp_h(cfg_wdata) : h_eff;

  // pixel path
  logic [7:0]  b_r, g_r, r_r, a_r;
  logic [19:0] mix_r;
  logic [27:0] prod_r;
  logic [28:0] prod_up;
  logic [7:0]  gray_r, gray_nxt;
  logic [15:0] mem [MAX_WIDTH];
  logic [15:0] rd_r;

  // frame state
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [WW-1:0] minc_r, maxc_r;
  logic [HW-1:0] minr_r, maxr_r;
  logic [7:0]    wc0_r [3];
  logic [7:0]    wc1_r [3];
  logic          edge_r;
  logic [1:0]    lx0_r, lx1_r, ly0_r, ly1_r;

  logic col_last, row_last, win_ok;
  assign col_last = ((WW+1)'(col_r) + (WW+1)'(1)) >= (WW+1)'(w_eff);
  assign row_last = ((HW+1)'(row_r) + (HW+1)'(1)) >= (HW+1)'(h_eff);
  assign win_ok   = (col_r >= CW'(2)) && (row_r >= RW'(2));
  assign sts.last_pix = col_last && row_last;
  assign sts.out_free = !out_tvalid || out_tready;

  assign prod_up = 29'(prod_r) + 29'((1 << ALPHA_SHIFT) - 1);

  always_comb begin
    logic [9:0] q;
    q = 10'(prod_up >> ALPHA_SHIFT);
    unique case (mode_r)
      MODE_GRAY: gray_nxt = b_r;
      MODE_BGRA: gray_nxt = (q > 10'd255) ? 8'd255 : q[7:0];
      MODE_BGR, MODE_BGRX: gray_nxt = mix_r[MIX_SHIFT+7:MIX_SHIFT];
      default: gray_nxt = b_r;
    endcase
  end

  // window: m[0..8] row by row
  logic [7:0] m [9];
  always_comb begin
    m[0] = wc0_r[0]; m[1] = wc1_r[0]; m[2] = rd_r[15:8];
    m[3] = wc0_r[1]; m[4] = wc1_r[1]; m[5] = rd_r[7:0];
    m[6] = wc0_r[2]; m[7] = wc1_r[2]; m[8] = gray_r;
  end

  logic signed [13:0] gx, gy;
  logic [13:0] mag;
  logic [1:0]  lx0, lx1, ly0, ly1;

  always_comb begin
    logic hit;
    gx = 14'sd3 * $signed({6'd0, m[0]}) + 14'sd10 * $signed({6'd0, m[3]})
       + 14'sd3 * $signed({6'd0, m[6]}) - 14'sd3 * $signed({6'd0, m[2]})
       - 14'sd10 * $signed({6'd0, m[5]}) - 14'sd3 * $signed({6'd0, m[8]});
    gy = 14'sd3 * $signed({6'd0, m[0]}) + 14'sd10 * $signed({6'd0, m[1]})
       + 14'sd3 * $signed({6'd0, m[2]}) - 14'sd3 * $signed({6'd0, m[6]})
       - 14'sd10 * $signed({6'd0, m[7]}) - 14'sd3 * $signed({6'd0, m[8]});
    mag = (gx < 0 ? 14'(-gx) : 14'(gx)) + (gy < 0 ? 14'(-gy) : 14'(gy));
    lx0 = 2'd2; ly0 = 2'd2; lx1 = 2'd1; ly1 = 2'd1;
    for (int i = 0; i < 3; i++) begin
      hit = 1'b0;
      if (absdiff8(m[i*3], m[i*3+1]) > thr_r) begin
        if (lx0 > 2'd1) lx0 = 2'd1;
        if (lx1 < 2'd1) lx1 = 2'd1;
        hit = 1'b1;
      end
      if (absdiff8(m[i*3+1], m[i*3+2]) > thr_r) begin
        if (lx1 < 2'd2) lx1 = 2'd2;
        hit = 1'b1;
      end
      if (hit) begin
        if (ly0 > 2'(i)) ly0 = 2'(i);
        if (ly1 < 2'(i+1)) ly1 = 2'(i+1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      hit = 1'b0;
      if (absdiff8(m[i], m[i+3]) > thr_r) begin
        if (ly0 > 2'd1) ly0 = 2'd1;
        if (ly1 < 2'd1) ly1 = 2'd1;
        hit = 1'b1;
      end
      if (absdiff8(m[i+3], m[i+6]) > thr_r) begin
        if (ly1 < 2'd2) ly1 = 2'd2;
        hit = 1'b1;
      end
      if (hit) begin
        if (lx0 > 2'(i)) lx0 = 2'(i);
        if (lx1 < 2'(i+1)) lx1 = 2'(i+1);
      end
    end
  end

  // absolute local box: rel + pos - 2
  logic [WW:0] ax0, ax1;
  logic [HW:0] ay0, ay1;
  assign ax0 = (WW+1)'(lx0_r) + (WW+1)'(col_r) - (WW+1)'(2);
  assign ax1 = (WW+1)'(lx1_r) + (WW+1)'(col_r) - (WW+1)'(2);
  assign ay0 = (HW+1)'(ly0_r) + (HW+1)'(row_r) - (HW+1)'(2);
  assign ay1 = (HW+1)'(ly1_r) + (HW+1)'(row_r) - (HW+1)'(2);

  // line store
  always_ff @(posedge clk) begin
    if (cmd.accept) rd_r <= mem[col_r];
    if (cmd.merge)  mem[col_r] <= {rd_r[7:0], gray_r};
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      b_r <= in_tdata[7:0];
      g_r <= in_tdata[15:8];
      r_r <= in_tdata[23:16];
      a_r <= in_tdata[31:24];
    end
    if (cmd.mix)
      mix_r <= 20'(COEF_B * b_r) + 20'(COEF_G * g_r) + 20'(COEF_R * r_r);
    if (cmd.prod)  prod_r <= 28'(mix_r * a_r);
    if (cmd.shade) gray_r <= gray_nxt;
    if (cmd.grad) begin
      edge_r <= win_ok && (mag > 14'(thr_r));
      lx0_r <= lx0; lx1_r <= lx1; ly0_r <= ly0; ly1_r <= ly1;
    end
  end

  // frame and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= 8'd0;
      width_r  <= 12'd2048;
      height_r <= 13'd4096;
      mode_r   <= MODE_BGRX;
      col_r    <= '0;
      row_r    <= '0;
      minc_r   <= clamp_w(12'd2048);
      maxc_r   <= '0;
      minr_r   <= clamp_h(13'd4096);
      maxr_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        wc0_r[i] <= 8'd0;
        wc1_r[i] <= 8'd0;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_THRESHOLD: thr_r    <= cfg_wdata[7:0];
          REG_WIDTH:     width_r  <= cfg_wdata[11:0];
          REG_HEIGHT:    height_r <= cfg_wdata;
          REG_MODE:      mode_r   <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (cmd.merge) begin
        if (edge_r) begin
          if (ax0 < (WW+1)'(minc_r)) minc_r <= WW'(ax0);
          if (ax1 > (WW+1)'(maxc_r)) maxc_r <= WW'(ax1);
          if (ay0 < (HW+1)'(minr_r)) minr_r <= HW'(ay0);
          if (ay1 > (HW+1)'(maxr_r)) maxr_r <= HW'(ay1);
        end
        for (int i = 0; i < 3; i++) wc0_r[i] <= wc1_r[i];
        wc1_r[0] <= rd_r[15:8];
        wc1_r[1] <= rd_r[7:0];
        wc1_r[2] <= gray_r;
        if (!(col_last && row_last)) begin
          if (col_last) begin
            col_r <= '0;
            row_r <= row_r + RW'(1);
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
      end
      if (cmd.emit || geo_wr) begin
        col_r  <= '0;
        row_r  <= '0;
        minc_r <= w_start;
        maxc_r <= '0;
        minr_r <= h_start;
        maxr_r <= '0;
      end
    end
  end

  // result register
  logic        blank;
  logic [11:0] res_l, res_r;
  logic [12:0] res_t, res_b;
  assign blank = (w_eff < WW'(3)) || (h_eff < HW'(3)) ||
                 (minc_r == w_eff && maxc_r == '0 && minr_r == h_eff && maxr_r == '0);
  assign res_l = blank ? 12'd0 : 12'(minc_r);
  assign res_t = blank ? 13'd0 : 13'(minr_r);
  assign res_r = blank ? 12'(w_eff) : 12'(maxc_r);
  assign res_b = blank ? 13'(h_eff) : 13'(maxr_r);

  logic out_valid_r;
  logic [55:0] out_data_r;
  logic out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {6'd0, res_b, res_r, res_t, res_l};
      out_user_r <= !blank;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: rtl/core/edge_content_bounding_box_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_content_bounding_box_core
// Scharr edge scan of a raster pixel stream; emits the content bounding box.
//
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tdata: blue, green, red, alpha
// out_     out  tvalid/tready      tdata: box l/t/r/b, tuser: content_found
// cfg_     in   wr_en              addr 0 thr, 1 width, 2 height, 3 mode
//
// Each pixel passes an accept step and a five-step sequencer (mix, alpha
// product, shade, gradient, merge) over one line store port; no new pixel
// is accepted before merge; a frame's last pixel adds a result load step.
// Reset is synchronous; the line store needs no clear.
// A stalled result only holds the block once the next frame ends.
// ----------------------------------------------------------------------------
module edge_content_bounding_box_core import ecbb_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // blue, green, red, alpha
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // box_left, box_top, box_right, box_bottom
  output logic        out_tuser,  // content_found
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  ecbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ecbb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: tb/ecbb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecbb_checker
// Watches the pixel, result and register ports of the bounding box core,
// predicts each frame's content box from the accepted pixels and compares
// every result item field by field with the oldest predicted box.
// ----------------------------------------------------------------------------
module ecbb_checker import ecbb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // blue, green, red, alpha
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // box_left, box_top, box_right, box_bottom
  input  logic        out_tuser,  // content_found
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  localparam int MAXW = 2048;
  localparam int MAXH = 4096;

  typedef struct {
    logic [11:0] left;
    logic [12:0] top;
    logic [11:0] right;
    logic [12:0] bottom;
    logic        found;
  } box_t;

  box_t        box_q[$];
  logic [7:0]  thr;
  logic [11:0] wreg;
  logic [12:0] hreg;
  logic [1:0]  mode;
  logic [15:0] store [MAXW];
  int          win [2][3];
  int          col, row, minc, maxc, minr, maxr;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int eff_w();
    return (wreg < 1) ? 1 : (wreg > MAXW) ? MAXW : int'(wreg);
  endfunction

  function automatic int eff_h();
    return (hreg < 1) ? 1 : (hreg > MAXH) ? MAXH : int'(hreg);
  endfunction

  task automatic restart_frame();
    col  = 0;
    row  = 0;
    minc = eff_w();
    maxc = 0;
    minr = eff_h();
    maxr = 0;
  endtask

  function automatic int shade_of(logic [31:0] px);
    longint mixv;
    longint v;
    mixv = 233 * longint'(px[7:0]) + 1197 * longint'(px[15:8]) + 610 * longint'(px[23:16]);
    if (mode == MODE_GRAY) return int'(px[7:0]);
    if (mode == MODE_BGRA) begin
      v = (mixv * longint'(px[31:24]) + 524287) / 524288;
      return (v > 255) ? 255 : int'(v);
    end
    return int'(mixv / 2048);
  endfunction

  function automatic int adiff(int x, int y);
    return (x > y) ? x - y : y - x;
  endfunction

  task automatic scan_window(int m[9], int cx, int cy);
    int gx, gy, mag, lx0, ly0, lx1, ly1, i;
    bit hit;
    gx = 3*m[0] + 10*m[3] + 3*m[6] - 3*m[2] - 10*m[5] - 3*m[8];
    gy = 3*m[0] + 10*m[1] + 3*m[2] - 3*m[6] - 10*m[7] - 3*m[8];
    mag = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
    lx0 = 2; ly0 = 2; lx1 = 1; ly1 = 1;
    if (mag <= int'(thr)) return;
    for (i = 0; i < 3; i++) begin
      hit = 0;
      if (adiff(m[i*3], m[i*3+1]) > int'(thr)) begin
        if (lx0 > 1) lx0 = 1;
        if (lx1 < 1) lx1 = 1;
        hit = 1;
      end
      if (adiff(m[i*3+1], m[i*3+2]) > int'(thr)) begin
        if (lx0 > 2) lx0 = 2;
        if (lx1 < 2) lx1 = 2;
        hit = 1;
      end
      if (hit) begin
        if (ly0 > i) ly0 = i;
        if (ly1 < i + 1) ly1 = i + 1;
      end
    end
    for (i = 0; i < 3; i++) begin
      hit = 0;
      if (adiff(m[i], m[i+3]) > int'(thr)) begin
        if (ly0 > 1) ly0 = 1;
        if (ly1 < 1) ly1 = 1;
        hit = 1;
      end
      if (adiff(m[i+3], m[i+6]) > int'(thr)) begin
        if (ly0 > 2) ly0 = 2;
        if (ly1 < 2) ly1 = 2;
        hit = 1;
      end
      if (hit) begin
        if (lx0 > i) lx0 = i;
        if (lx1 < i + 1) lx1 = i + 1;
      end
    end
    lx0 += cx - 1; lx1 += cx - 1;
    ly0 += cy - 1; ly1 += cy - 1;
    if (lx0 < minc) minc = lx0;
    if (lx1 > maxc) maxc = lx1;
    if (ly0 < minr) minr = ly0;
    if (ly1 > maxr) maxr = ly1;
  endtask

  task automatic take_pixel(logic [31:0] px);
    int w, h, c, r, g, slot, top, mid;
    int m[9];
    box_t b;
    w = eff_w();
    h = eff_h();
    c = col;
    r = row;
    g = shade_of(px);
    slot = c % MAXW;
    top = store[slot][15:8];
    mid = store[slot][7:0];
    store[slot] = {mid[7:0], g[7:0]};
    if (c >= 2 && r >= 2) begin
      m[0] = win[0][0]; m[1] = win[1][0]; m[2] = top;
      m[3] = win[0][1]; m[4] = win[1][1]; m[5] = mid;
      m[6] = win[0][2]; m[7] = win[1][2]; m[8] = g;
      scan_window(m, c - 1, r - 1);
    end
    win[0] = win[1];
    win[1][0] = top;
    win[1][1] = mid;
    win[1][2] = g;
    if (c + 1 >= w && r + 1 >= h) begin
      if (w < 3 || h < 3 || (minc == w && maxc == 0 && minr == h && maxr == 0)) begin
        b.left = '0; b.top = '0; b.right = w[11:0]; b.bottom = h[12:0]; b.found = 0;
      end else begin
        b.left = minc[11:0]; b.top = minr[12:0];
        b.right = maxc[11:0]; b.bottom = maxr[12:0]; b.found = 1;
      end
      box_q.push_back(b);
      restart_frame();
    end else if (c + 1 >= w) begin
      col = 0;
      row = r + 1;
    end else begin
      col = c + 1;
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("ecbb_checker: %s got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    box_t b;
    if (!rst_n) begin
      thr  = 8'd0;
      wreg = 12'd2048;
      hreg = 13'd4096;
      mode = MODE_BGRX;
      foreach (store[i]) store[i] = '0;
      foreach (win[i, j]) win[i][j] = 0;
      restart_frame();
      box_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (box_q.size() == 0) begin
          report("result item with none expected, left", out_tdata[11:0], -1);
        end else begin
          b = box_q.pop_front();
          if (out_tdata[11:0] !== b.left)    report("box_left", out_tdata[11:0], b.left);
          if (out_tdata[24:12] !== b.top)    report("box_top", out_tdata[24:12], b.top);
          if (out_tdata[36:25] !== b.right)  report("box_right", out_tdata[36:25], b.right);
          if (out_tdata[49:37] !== b.bottom) report("box_bottom", out_tdata[49:37], b.bottom);
          if (out_tuser !== b.found)         report("content_found", out_tuser, b.found);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_THRESHOLD: thr = cfg_wdata[7:0];
          REG_WIDTH: begin
            wreg = cfg_wdata[11:0];
            restart_frame();
          end
          REG_HEIGHT: begin
            hreg = cfg_wdata[12:0];
            restart_frame();
          end
          REG_MODE: mode = cfg_wdata[1:0];
        endcase
      end
      if (in_tvalid && in_tready) take_pixel(in_tdata);
    end
    pending = box_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frames of pixels through the edge content bounding box core under
// a range of geometries, modes and thresholds, with random idling on both
// sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top import ecbb_pkg::*;;

  localparam int LIMIT = 2000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en = 0;
  logic [1:0]  cfg_addr = '0;
  logic [12:0] cfg_wdata = '0;

  int errors, pending;
  int cycles = 0;
  int sent = 0;
  bit quiet = 0;
  bit calm = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  int out_gap = 0;

  always #1 clk = ~clk;

  edge_content_bounding_box_core u_top (.*);

  ecbb_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // result side: long hold on request, else random stall bursts
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_tready <= 0;
      if (hold_cnt == 600) hold_done <= 1;
      else hold_cnt <= hold_cnt + 1;
    end else if (out_gap > 0) begin
      out_tready <= 0;
      out_gap <= out_gap - 1;
    end else if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
      out_tready <= 0;
      out_gap <= $urandom_range(0, 14);
    end else begin
      out_tready <= 1;
    end
  end

  task automatic write_reg(logic [1:0] a, logic [12:0] v);
    cfg_wr_en <= 1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic setup(int th, int w, int h, logic [1:0] md);
    write_reg(REG_THRESHOLD, th[12:0]);
    write_reg(REG_WIDTH, w[12:0]);
    write_reg(REG_HEIGHT, h[12:0]);
    write_reg(REG_MODE, {11'd0, md});
    cfg_wr_en <= 0;
  endtask

  task automatic send_pixel(logic [31:0] px);
    if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= px;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_frame(int w, int h);
    int style, x0, x1, y0, y1, r, c;
    logic [31:0] bg, fg, px;
    style = $urandom_range(0, 3);
    bg = $urandom;
    fg = $urandom;
    x0 = $urandom_range(0, w);
    x1 = $urandom_range(0, w);
    y0 = $urandom_range(0, h);
    y1 = $urandom_range(0, h);
    calm = ($urandom_range(0, 3) == 0);
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        case (style)
          0: px = $urandom;
          1: px = (c >= x0 && c < x1 && r >= y0 && r < y1) ? fg : bg;
          2: px = ($urandom_range(0, 9) == 0) ? $urandom : bg;
          default: px = bg;
        endcase
        send_pixel(px);
      end
    end
    drain();
  endtask

  initial begin
    int i, th, w, h;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // gray checkerboard, zero threshold
    setup(0, 3, 3, MODE_GRAY);
    for (i = 0; i < 9; i++) send_pixel((i % 2) ? 32'h000000ff : 32'hffffff00);
    drain();

    // alpha weighted at top threshold: clamp, zero and full alpha
    setup(255, 4, 3, MODE_BGRA);
    for (i = 0; i < 12; i++) begin
      case (i % 4)
        0: send_pixel(32'hffffffff);
        1: send_pixel(32'h00ffffff);
        2: send_pixel(32'hff000000);
        default: send_pixel(32'h80ff00ff);
      endcase
    end
    drain();

    // zero geometry is one pixel per frame
    setup(7, 0, 0, MODE_BGR);
    for (i = 0; i < 3; i++) send_pixel($urandom);
    drain();

    // receiver holds off while 1x1 frames keep coming
    hold_req <= 1;
    for (i = 0; i < 40; i++) send_pixel($urandom);
    drain();

    // oversized geometry, left unfinished; the next setup restarts the frame
    setup(20, 4095, 8191, MODE_BGRX);
    for (i = 0; i < 20; i++) send_pixel($urandom);
    drain();

    while (sent < 400) begin
      if (sent > 340) quiet = 1;
      th = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 255 : 0)
                                       : $urandom_range(0, 80);
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
      h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      setup(th, w, h, 2'($urandom_range(0, 3)));
      send_frame((w < 1) ? 1 : w, (h < 1) ? 1 : h);
    end

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
